FILE: rtl/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MPROD_W = 2 * SAMPLE_W;
  localparam int PROD_W = 33;
  localparam int MAG_W = 16;
  localparam int DEN_W = MAG_W + 1;
  localparam int QUO_W = 16;
  localparam int TERM_W = QUO_W + 1;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int FREQ_W = 18;
  localparam int SUM_W = 17;
  localparam int DRIVE_W = 8;
  localparam int DRIVE_SH = 8;
  localparam int SCALE_SH = 16;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int MUL_STEPS = 4;
  localparam int STEP_W = 3;
  localparam int BLOCK_LEN_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'b1;
  localparam logic [CFG_W-1:0] OFFSET_RST = 8'd100;
  localparam logic [CFG_W-1:0] LIMIT_RST = 8'd200;

  // Largest magnitude that is kept without the coarse rescale.
  localparam logic signed [PROD_W-1:0] SMALL_MAX = 33'sd32767;
  localparam logic signed [PROD_W-1:0] SCALE_BIAS = PROD_W'((64'sd1 <<< SCALE_SH) - 1);
  localparam logic signed [FREQ_W-1:0] DRIVE_BIAS = FREQ_W'((64'sd1 <<< DRIVE_SH) - 1);

  // Which partial product of the conjugate multiply is addressed.
  typedef enum logic [1:0] {
    MUL_II,
    MUL_QQ,
    MUL_QI,
    MUL_IQ
  } mul_op_t;

  typedef struct packed {
    logic    capture;
    logic    mul_go;
    mul_op_t mul_op;
    logic    mul_acc;
    mul_op_t acc_op;
    logic    scale;
    logic    prep;
    logic    div_step;
    logic    commit;
    logic    emit;
  } ifd_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ifd_if.sv
`default_nettype none

interface ifd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ifd_pkg::SAMPLE_W-1:0]    sample_i;
  logic signed [ifd_pkg::SAMPLE_W-1:0]    sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface ifd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ifd_pkg::DRIVE_W-1:0]          drive_value;
  logic signed [ifd_pkg::SUM_W-1:0]     block_sum_i;
  logic signed [ifd_pkg::SUM_W-1:0]     block_sum_q;

  modport source (output valid, output drive_value, output block_sum_i,
                  output block_sum_q, input ready);
  modport sink (input valid, input drive_value, input block_sum_i,
                input block_sum_q, output ready);
endinterface

`default_nettype wire

FILE: rtl/ifd_ctrl.sv
`default_nettype none

module ifd_ctrl #(
  parameter int BLOCK_LEN = ifd_pkg::BLOCK_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output ifd_pkg::ifd_cmd_t      cmd
);

  localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_LEN - 1);
  localparam logic [ifd_pkg::STEP_W-1:0] LAST_STEP = ifd_pkg::STEP_W'(ifd_pkg::MUL_STEPS);
  localparam logic [ifd_pkg::DIV_CNT_W-1:0] LAST_DIV =
    ifd_pkg::DIV_CNT_W'(ifd_pkg::QUO_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_PREP,
    S_DIV,
    S_COMMIT,
    S_EMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ifd_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [ifd_pkg::STEP_W-1:0]      step_m1;
  logic [ifd_pkg::DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign step_m1 = step_r - ifd_pkg::STEP_W'(1);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    div_cnt_nxt = div_cnt_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL;
          step_nxt = '0;
        end
      end
      S_MUL: begin
        step_nxt = step_r + ifd_pkg::STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_DIV;
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r + ifd_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == LAST_DIV) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (cnt_r == LAST_CNT) begin
          cnt_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      div_cnt_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      div_cnt_r <= div_cnt_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.mul_go = (state_r == S_MUL) && (step_r != LAST_STEP);
    cmd.mul_op = ifd_pkg::mul_op_t'(step_r[1:0]);
    cmd.mul_acc = (state_r == S_MUL) && (step_r != '0);
    cmd.acc_op = ifd_pkg::mul_op_t'(step_m1[1:0]);
    cmd.scale = (state_r == S_SCALE);
    cmd.prep = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.commit = (state_r == S_COMMIT);
    cmd.emit = (state_r == S_EMIT) && slot_free;
  end

endmodule

`default_nettype wire

FILE: rtl/ifd_dpath.sv
`default_nettype none

module ifd_dpath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire ifd_pkg::ifd_cmd_t                      cmd,
  input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]    sample_i,
  input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]    sample_q,
  input  wire logic                                   cfg_we,
  input  wire logic [ifd_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  wire logic [ifd_pkg::CFG_W-1:0]              cfg_data,
  output logic [ifd_pkg::DRIVE_W-1:0]                 drive_value,
  output logic signed [ifd_pkg::SUM_W-1:0]            block_sum_i,
  output logic signed [ifd_pkg::SUM_W-1:0]            block_sum_q
);

  localparam int PW = ifd_pkg::PROD_W;
  localparam int FW = ifd_pkg::FREQ_W;
  localparam int SW = ifd_pkg::SAMPLE_W;
  localparam int QW = ifd_pkg::QUO_W;
  localparam int MW = ifd_pkg::MAG_W;
  localparam int DW = ifd_pkg::DEN_W;
  localparam int SUMW = ifd_pkg::SUM_W;
  localparam int OW = ifd_pkg::DRIVE_W;
  localparam int QDW = FW - ifd_pkg::DRIVE_SH;
  localparam int DRV_W = QDW + 1;

  // Truncating division by 2^16 toward zero.
  function automatic logic signed [PW-1:0] coarse(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] biased;
    biased = x[PW-1] ? (x + ifd_pkg::SCALE_BIAS) : x;
    return biased >>> ifd_pkg::SCALE_SH;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] a;
    a = x[PW-1] ? -x : x;
    return a[MW-1:0];
  endfunction

  logic signed [SW-1:0]    cur_i_r, cur_q_r;
  logic signed [SW-1:0]    prev_i_r, prev_q_r;
  logic signed [SW-1:0]    op_a, op_b;
  logic signed [ifd_pkg::MPROD_W-1:0] prod, prod_r;
  logic signed [PW-1:0]    prod_ext;
  logic signed [PW-1:0]    fi_r, fq_r;
  logic                    big;
  logic [MW-1:0]           mag_i, mag_q;
  logic [DW-1:0]           den_r;
  logic [DW-1:0]           rem_r;
  logic [QW-1:0]           dvd_r;
  logic                    neg_r, zero_r;
  logic [DW-1:0]           trial;
  logic                    ge;
  logic [QW-1:0]           quo;
  logic signed [ifd_pkg::TERM_W-1:0] term;
  logic signed [FW:0]      freq_sum;
  logic signed [FW-1:0]    freq_sat;
  logic signed [FW-1:0]    freq_r;
  logic signed [SUMW-1:0]  sum_i_r, sum_q_r;
  logic [ifd_pkg::CFG_W-1:0] offset_r, limit_r;
  logic signed [FW-1:0]    freq_biased;
  logic signed [QDW-1:0]   freq_div;
  logic signed [DRV_W-1:0] drv;
  logic [OW-1:0]           drv_clamped;
  logic [OW-1:0]           drive_r;
  logic signed [SUMW-1:0]  bsum_i_r, bsum_q_r;

  // Conjugate multiply, one partial product per cycle.
  always_comb begin
    unique case (cmd.mul_op)
      ifd_pkg::MUL_II: begin
        op_a = cur_i_r;
        op_b = prev_i_r;
      end
      ifd_pkg::MUL_QQ: begin
        op_a = cur_q_r;
        op_b = prev_q_r;
      end
      ifd_pkg::MUL_QI: begin
        op_a = cur_q_r;
        op_b = prev_i_r;
      end
      ifd_pkg::MUL_IQ: begin
        op_a = cur_i_r;
        op_b = prev_q_r;
      end
      default: begin
        op_a = cur_i_r;
        op_b = prev_i_r;
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign prod_ext = PW'(prod_r);

  assign big = (fi_r > ifd_pkg::SMALL_MAX) || (fi_r < -ifd_pkg::SMALL_MAX) ||
               (fq_r > ifd_pkg::SMALL_MAX) || (fq_r < -ifd_pkg::SMALL_MAX);
  assign mag_i = mag(fi_r);
  assign mag_q = mag(fq_r);

  // Restoring division step; the quotient shifts in behind the dividend bits.
  assign trial = {rem_r[DW-2:0], dvd_r[QW-1]};
  assign ge = (trial >= den_r);

  assign quo = zero_r ? '0 : dvd_r;
  assign term = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign freq_sum = (FW + 1)'(freq_r) + (FW + 1)'(term);

  always_comb begin
    if (freq_sum[FW] != freq_sum[FW-1]) begin
      freq_sat = freq_sum[FW] ? {1'b1, {(FW - 1){1'b0}}} : {1'b0, {(FW - 1){1'b1}}};
    end else begin
      freq_sat = freq_sum[FW-1:0];
    end
  end

  assign freq_biased = freq_r[FW-1] ? (freq_r + ifd_pkg::DRIVE_BIAS) : freq_r;
  assign freq_div = freq_biased[FW-1:ifd_pkg::DRIVE_SH];
  assign drv = DRV_W'(freq_div) + $signed({{(DRV_W - ifd_pkg::CFG_W){1'b0}}, offset_r});

  always_comb begin
    priority if (drv[DRV_W-1]) begin
      drv_clamped = '0;
    end else if (drv > $signed({{(DRV_W - ifd_pkg::CFG_W){1'b0}}, limit_r})) begin
      drv_clamped = limit_r;
    end else begin
      drv_clamped = drv[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= ifd_pkg::OFFSET_RST;
      limit_r <= ifd_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ifd_pkg::CFG_OUTPUT_OFFSET: offset_r <= cfg_data;
        ifd_pkg::CFG_OUTPUT_LIMIT:  limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r <= '0;
      prev_q_r <= '0;
      freq_r <= '0;
      sum_i_r <= '0;
      sum_q_r <= '0;
    end else if (cmd.commit) begin
      prev_i_r <= cur_i_r;
      prev_q_r <= cur_q_r;
      freq_r <= freq_sat;
      sum_i_r <= sum_i_r + SUMW'(cur_i_r);
      sum_q_r <= sum_q_r + SUMW'(cur_q_r);
    end else if (cmd.emit) begin
      freq_r <= '0;
      sum_i_r <= '0;
      sum_q_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_i_r <= sample_i;
      cur_q_r <= sample_q;
    end
    if (cmd.mul_go) begin
      prod_r <= prod;
    end
    if (cmd.mul_acc) begin
      unique case (cmd.acc_op)
        ifd_pkg::MUL_II: fi_r <= prod_ext;
        ifd_pkg::MUL_QQ: fi_r <= fi_r + prod_ext;
        ifd_pkg::MUL_QI: fq_r <= prod_ext;
        ifd_pkg::MUL_IQ: fq_r <= fq_r - prod_ext;
        default: ;
      endcase
    end
    if (cmd.scale && big) begin
      fi_r <= coarse(fi_r);
      fq_r <= coarse(fq_r);
    end
    if (cmd.prep) begin
      den_r <= {1'b0, mag_i} + {1'b0, mag_q};
      zero_r <= (mag_i == '0) && (mag_q == '0);
      neg_r <= fq_r[PW-1];
      // The dividend is |fq| * 2^15; its top bits seed the remainder.
      rem_r <= DW'(mag_q[MW-1:1]);
      dvd_r <= {mag_q[0], {(QW - 1){1'b0}}};
    end
    if (cmd.div_step) begin
      rem_r <= ge ? (trial - den_r) : trial;
      dvd_r <= {dvd_r[QW-2:0], ge};
    end
    if (cmd.emit) begin
      drive_r <= drv_clamped;
      bsum_i_r <= sum_i_r;
      bsum_q_r <= sum_q_r;
    end
  end

  assign drive_value = drive_r;
  assign block_sum_i = bsum_i_r;
  assign block_sum_q = bsum_q_r;

endmodule

`default_nettype wire

FILE: rtl/iq_fm_discriminator.sv
`default_nettype none

// Channel   Dir  Payload                                      Handshake
// in_ch     in   sample_i[15:0], sample_q[15:0] (signed)      valid/ready
// out_ch    out  drive_value[7:0], block_sum_i/q[16:0] (s)    valid/ready
// cfg       in   cfg_idx[0], cfg_data[7:0]                    cfg_we, no stall
//
// After acceptance, a sample passes through the shared 16x16 multiplier, rescale and
// divisor setup, the one-bit-per-cycle restoring divider and an accumulator update
// before in_ch.ready is high again. The last sample of a block also loads the
// output register, and waits while that register still holds an earlier result
// that has not been taken. Reset is synchronous and active low; the output register
// frees a new sample to be accepted while the previous result waits.

module iq_fm_discriminator #(
  parameter int BLOCK_LEN = ifd_pkg::BLOCK_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ifd_in_if.sink                                 in_ch,
  ifd_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [ifd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ifd_pkg::CFG_W-1:0]         cfg_data
);

  ifd_pkg::ifd_cmd_t  ctl_cmd;
  logic               in_ready;
  logic               out_valid;

  ifd_ctrl #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (ctl_cmd)
  );

  ifd_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctl_cmd),
    .sample_i    (in_ch.sample_i),
    .sample_q    (in_ch.sample_q),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .drive_value (out_ch.drive_value),
    .block_sum_i (out_ch.block_sum_i),
    .block_sum_q (out_ch.block_sum_q)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;

  // A request starts a long computation, so no second one is taken right after it.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while the previous one was still in work");

  // A result appears only after the datapath has loaded the output register.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctl_cmd.emit))
    else $error("result valid without an output load");

  // The output register is never overwritten while it holds an untaken result.
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

FILE: verif/tb_iq_fm_discriminator.sv
`timescale 1ns / 100ps

module tb_iq_fm_discriminator;

  localparam int BLOCK_LEN = ifd_pkg::BLOCK_LEN_DEF;
  localparam int SAMPLE_W = ifd_pkg::SAMPLE_W;
  localparam int SUM_W = ifd_pkg::SUM_W;
  localparam int DRIVE_W = ifd_pkg::DRIVE_W;
  localparam int FREQ_W = ifd_pkg::FREQ_W;
  localparam int CFG_W = ifd_pkg::CFG_W;
  localparam int CFG_IDX_W = ifd_pkg::CFG_IDX_W;
  localparam longint SMALL_MAG = 32767;
  localparam longint RESCALE_DIV = 65536;
  localparam longint TERM_GAIN = 32768;
  localparam longint DRIVE_DIV = 256;
  localparam longint FREQ_MAX = 131071;
  localparam longint FREQ_MIN = -131072;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    logic [DRIVE_W-1:0]       drive;
    logic signed [SUM_W-1:0]  sum_i;
    logic signed [SUM_W-1:0]  sum_q;
  } block_result_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  a;
    logic signed [SAMPLE_W-1:0]  b;
    logic                        known;
    block_result_t               res;
  } stim_row_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH
  } flow_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  ifd_in_if in_ch ();
  ifd_out_if out_ch ();

  iq_fm_discriminator #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state, kept in step with every accepted request.
  logic signed [SAMPLE_W-1:0] prev_i, prev_q;
  logic signed [FREQ_W-1:0] freq_acc;
  logic signed [SUM_W-1:0] sum_i, sum_q;
  int block_fill;
  logic [CFG_W-1:0] offset_reg, limit_reg;

  block_result_t pending_blocks[$];
  stim_row_t directed_rows[$];

  int mismatch_count = 0;
  int samples_sent = 0;
  int blocks_checked = 0;
  int settings_used = 0;
  int sender_pct = 0;
  int receiver_pct = 0;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Advances the discriminator by one sample; returns 1 when a block completes.
  function automatic bit demod_sample(input logic signed [SAMPLE_W-1:0] si,
                                      input logic signed [SAMPLE_W-1:0] sq,
                                      output block_result_t res);
    longint fi, fq, den, term, acc, drive;
    fi = longint'(si) * longint'(prev_i) + longint'(sq) * longint'(prev_q);
    fq = longint'(sq) * longint'(prev_i) - longint'(si) * longint'(prev_q);
    if (magnitude(fi) > SMALL_MAG || magnitude(fq) > SMALL_MAG) begin
      fi = fi / RESCALE_DIV;
      fq = fq / RESCALE_DIV;
    end
    den = magnitude(fi) + magnitude(fq);
    term = (den == 0) ? 0 : (TERM_GAIN * fq) / den;
    acc = longint'(freq_acc) + term;
    if (acc > FREQ_MAX) acc = FREQ_MAX;
    if (acc < FREQ_MIN) acc = FREQ_MIN;
    freq_acc = FREQ_W'(acc);
    prev_i = si;
    prev_q = sq;
    sum_i = sum_i + si;
    sum_q = sum_q + sq;
    block_fill++;
    res = '0;
    if (block_fill < BLOCK_LEN) return 1'b0;
    drive = longint'(freq_acc) / DRIVE_DIV + longint'(offset_reg);
    if (drive < 0) drive = 0;
    if (drive > longint'(limit_reg)) drive = longint'(limit_reg);
    res.drive = DRIVE_W'(drive);
    res.sum_i = sum_i;
    res.sum_q = sum_q;
    freq_acc = '0;
    sum_i = '0;
    sum_q = '0;
    block_fill = 0;
    return 1'b1;
  endfunction

  function automatic stim_row_t sample_row(input int i, input int q);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.a = SAMPLE_W'(i);
    r.b = SAMPLE_W'(q);
    return r;
  endfunction

  function automatic stim_row_t known_row(input int i, input int q, input int drive,
                                          input int si, input int sq);
    stim_row_t r;
    r = sample_row(i, q);
    r.known = 1'b1;
    r.res.drive = DRIVE_W'(drive);
    r.res.sum_i = SUM_W'(si);
    r.res.sum_q = SUM_W'(sq);
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.a = SAMPLE_W'(idx);
    r.b = SAMPLE_W'(data);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return SAMPLE_W'($urandom);
    if (pick < 65) return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
    if (pick < 80) begin
      case ($urandom_range(0, 5))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh8001;
        3: return 16'shFFFF;
        4: return 16'sh0000;
        default: return 16'sh0001;
      endcase
    end
    return SAMPLE_W'(int'($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic void set_flow(input flow_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        sender_pct = 0;
        receiver_pct = 0;
      end
      FLOW_SENDER_IDLE: begin
        sender_pct = 45;
        receiver_pct = 0;
      end
      FLOW_RECEIVER_STALL: begin
        sender_pct = 0;
        receiver_pct = 45;
      end
      default: begin
        sender_pct = 6;
        receiver_pct = 6;
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                             input logic signed [SAMPLE_W-1:0] sq,
                             input logic known, input block_result_t known_res);
    block_result_t res;
    @(negedge clk);
    while (sender_pct > 0 && $urandom_range(0, 99) < sender_pct) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.sample_i <= si;
    in_ch.sample_q <= sq;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    if (demod_sample(si, sq, res)) pending_blocks.push_back(known ? known_res : res);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits for all outstanding results, then lets a sample still in the divider finish.
  task automatic drain_block_results();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ifd_pkg::CFG_OUTPUT_OFFSET: offset_reg = data;
      ifd_pkg::CFG_OUTPUT_LIMIT: limit_reg = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] offs, input logic [CFG_W-1:0] lim);
    drain_block_results();
    write_reg(ifd_pkg::CFG_OUTPUT_OFFSET, offs);
    write_reg(ifd_pkg::CFG_OUTPUT_LIMIT, lim);
    settings_used++;
  endtask

  always @(negedge clk) begin
    if (receiver_pct > 0 && $urandom_range(0, 99) < receiver_pct) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    block_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_blocks.size() == 0) begin
        $error("block result with nothing pending: drive_value %0d", out_ch.drive_value);
        mismatch_count++;
      end else begin
        want = pending_blocks.pop_front();
        blocks_checked++;
        if (out_ch.drive_value !== want.drive) begin
          $error("drive_value: expected %0d, actual %0d", want.drive, out_ch.drive_value);
          mismatch_count++;
        end
        if (out_ch.block_sum_i !== want.sum_i) begin
          $error("block_sum_i: expected %0d, actual %0d", want.sum_i, out_ch.block_sum_i);
          mismatch_count++;
        end
        if (out_ch.block_sum_q !== want.sum_q) begin
          $error("block_sum_q: expected %0d, actual %0d", want.sum_q, out_ch.block_sum_q);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    logic [CFG_W-1:0] offs, lim;
    in_ch.valid = 1'b0;
    in_ch.sample_i = '0;
    in_ch.sample_q = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    prev_i = '0;
    prev_q = '0;
    freq_acc = '0;
    sum_i = '0;
    sum_q = '0;
    block_fill = 0;
    offset_reg = ifd_pkg::OFFSET_RST;
    limit_reg = ifd_pkg::LIMIT_RST;

    // Silence first, then a steady tone: every term is zero, so the drive is the reset offset.
    directed_rows.push_back(sample_row(0, 0));
    directed_rows.push_back(known_row(0, 0, 100, 0, 0));
    directed_rows.push_back(sample_row(32767, 0));
    directed_rows.push_back(known_row(32767, 0, 100, 65534, 0));
    directed_rows.push_back(sample_row(-32768, -32768));
    directed_rows.push_back(sample_row(-32768, -32768));
    // A limit of zero pins the drive at zero.
    directed_rows.push_back(write_row(ifd_pkg::CFG_OUTPUT_LIMIT, 0));
    directed_rows.push_back(sample_row(1000, 0));
    directed_rows.push_back(known_row(0, 1000, 0, 1000, 1000));
    // Strong negative frequency with no offset clamps at zero.
    directed_rows.push_back(write_row(ifd_pkg::CFG_OUTPUT_OFFSET, 0));
    directed_rows.push_back(write_row(ifd_pkg::CFG_OUTPUT_LIMIT, 255));
    directed_rows.push_back(sample_row(100, 0));
    directed_rows.push_back(known_row(0, -100, 0, 100, -100));
    // Positive frequency on top of the largest offset clamps at the limit.
    directed_rows.push_back(write_row(ifd_pkg::CFG_OUTPUT_OFFSET, 255));
    directed_rows.push_back(sample_row(0, 100));
    directed_rows.push_back(known_row(-100, 0, 255, -100, 100));
    directed_rows.push_back(write_row(ifd_pkg::CFG_OUTPUT_OFFSET, 100));
    directed_rows.push_back(write_row(ifd_pkg::CFG_OUTPUT_LIMIT, 200));
    directed_rows.push_back(sample_row(32767, -32768));
    directed_rows.push_back(sample_row(-32768, 32767));
    directed_rows.push_back(sample_row(181, 0));
    directed_rows.push_back(sample_row(181, 0));
    directed_rows.push_back(sample_row(-182, 0));
    directed_rows.push_back(sample_row(1, 1));
    directed_rows.push_back(sample_row(-1, -1));
    directed_rows.push_back(sample_row(12345, -23456));
    directed_rows.push_back(sample_row(0, -32768));
    directed_rows.push_back(sample_row(-32768, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_flow(FLOW_FREE);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.kind == ROW_WRITE) begin
        drain_block_results();
        write_reg(row.a[CFG_IDX_W-1:0], row.b[CFG_W-1:0]);
      end else begin
        send_sample(row.a, row.b, row.known, row.res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          offs = 8'd0;
          lim = 8'd255;
        end
        1: begin
          offs = 8'd255;
          lim = 8'd0;
        end
        2: begin
          offs = 8'd128;
          lim = 8'd255;
        end
        4: begin
          offs = ifd_pkg::OFFSET_RST;
          lim = ifd_pkg::LIMIT_RST;
        end
        default: begin
          offs = CFG_W'($urandom);
          lim = CFG_W'($urandom);
        end
      endcase
      apply_setting(offs, lim);
      set_flow(flow_mode_t'(p % 4));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 59) == 0)
          while (pending_blocks.size() != 0) @(posedge clk);
        send_sample(pick_sample_value(), pick_sample_value(), 1'b0, '0);
      end
    end

    drain_block_results();
    $display("Sent %0d samples and checked %0d block results.", samples_sent, blocks_checked);
    $display("Used %0d register settings under four handshake pacing modes.", settings_used);
    if (mismatch_count == 0 && pending_blocks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ifd_pkg.sv
rtl/ifd_if.sv
rtl/ifd_ctrl.sv
rtl/ifd_dpath.sv
rtl/iq_fm_discriminator.sv
verif/tb_iq_fm_discriminator.sv
